>>> src/jksd_pkg.sv
// ----------------------------------------------------------------------------
// Joint keyframe stream decoder package
// Shared types, constants and slot helpers for the decoder front and back.
// ----------------------------------------------------------------------------
package jksd_pkg;

	localparam int NUM_SLOTS  = 9;
	localparam int SLOT_W     = 4;
	localparam int VAL_W      = 16;
	localparam int MAX_JOINTS = 256;
	localparam int JCNT_W     = 8;
	localparam int JLIM_W     = 9;
	localparam int FCNT_W     = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int Q_DEPTH    = 2;

	localparam logic [VAL_W-1:0] SCALE_ONE = 16'h0100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 8'd1;

	// slot order in the stream
	localparam logic [SLOT_W-1:0] SLOT_POS_X   = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_POS_Y   = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_POS_Z   = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_SCALE_X = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_SCALE_Z = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_SCALE_Y = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_PITCH   = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_YAW     = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_ROLL    = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_NONE    = 4'd9;

	typedef logic [VAL_W-1:0] field_t;

	typedef struct packed {
		logic                wr;
		logic [SLOT_W-1:0]   slot;
		field_t              value;
		logic                done;
	} token_t;

	typedef struct packed {
		field_t              pos_x;
		field_t              pos_y;
		field_t              pos_z;
		field_t              scale_x;
		field_t              scale_y;
		field_t              scale_z;
		field_t              pitch;
		field_t              yaw;
		field_t              roll;
		logic [JCNT_W-1:0]   joint_index;
		logic [FCNT_W-1:0]   frame_index;
		logic                sequence_end;
	} result_t;

	// flag bit that announces a slot; both scale x and z hang on bit 3
	function automatic logic [7:0] slot_mask(input logic [SLOT_W-1:0] slot);
		logic [7:0] m;
		case (slot)
			SLOT_POS_X:   m = 8'h01;
			SLOT_POS_Y:   m = 8'h02;
			SLOT_POS_Z:   m = 8'h04;
			SLOT_SCALE_X: m = 8'h08;
			SLOT_SCALE_Z: m = 8'h08;
			SLOT_SCALE_Y: m = 8'h10;
			SLOT_PITCH:   m = 8'h20;
			SLOT_YAW:     m = 8'h40;
			SLOT_ROLL:    m = 8'h80;
			default:      m = 8'h00;
		endcase
		return m;
	endfunction

	// first present slot at or after start, SLOT_NONE if there is none
	function automatic logic [SLOT_W-1:0] next_slot(input logic [7:0] flags,
			input logic [SLOT_W-1:0] start);
		logic [SLOT_W-1:0] res;
		logic              found;
		res   = SLOT_NONE;
		found = 1'b0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			if (!found && SLOT_W'(s) >= start &&
					(flags & slot_mask(SLOT_W'(s))) != 8'h00) begin
				res   = SLOT_W'(s);
				found = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic field_t slot_default(input logic [SLOT_W-1:0] slot);
		field_t v;
		case (slot)
			SLOT_SCALE_X, SLOT_SCALE_Y, SLOT_SCALE_Z: v = SCALE_ONE;
			default:                                  v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> src/jksd_front.sv
// ----------------------------------------------------------------------------
// Byte classifier
// Splits the byte stream into flag bytes and value halves, and hands each
// completed field (or an empty record) to the back end as one token.
// ----------------------------------------------------------------------------
module jksd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	output logic              tok_push,
	output jksd_pkg::token_t  tok
);
	import jksd_pkg::*;

	logic [7:0]        flag_q;
	logic              busy_q;
	logic [SLOT_W-1:0] slot_q;
	logic              pending_q;
	logic [7:0]        hold_q;

	logic [SLOT_W-1:0] first_slot;
	logic [SLOT_W-1:0] follow_slot;

	assign first_slot  = next_slot(data_byte, SLOT_POS_X);
	assign follow_slot = next_slot(flag_q, slot_q + SLOT_W'(1));

	always_comb begin
		tok_push   = 1'b0;
		tok.wr     = 1'b0;
		tok.slot   = slot_q;
		tok.value  = {data_byte, hold_q};
		tok.done   = 1'b0;
		if (take) begin
			if (!busy_q) begin
				// empty flag byte: record completes with all defaults
				tok_push = (first_slot == SLOT_NONE);
				tok.done = 1'b1;
			end else if (pending_q) begin
				tok_push = 1'b1;
				tok.wr   = 1'b1;
				tok.done = (follow_slot == SLOT_NONE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= '0;
			busy_q    <= 1'b0;
			slot_q    <= SLOT_POS_X;
			pending_q <= 1'b0;
			hold_q    <= '0;
		end else if (take) begin
			if (!busy_q) begin
				flag_q    <= data_byte;
				pending_q <= 1'b0;
				if (first_slot != SLOT_NONE) begin
					busy_q <= 1'b1;
					slot_q <= first_slot;
				end
			end else if (!pending_q) begin
				hold_q    <= data_byte;
				pending_q <= 1'b1;
			end else begin
				pending_q <= 1'b0;
				hold_q    <= '0;
				if (follow_slot == SLOT_NONE) begin
					busy_q <= 1'b0;
				end else begin
					slot_q <= follow_slot;
				end
			end
		end
	end

	a_pending_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> busy_q) else $error("low byte held outside a record");

	a_slot_present: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (slot_q < SLOT_NONE) && ((flag_q & slot_mask(slot_q)) != 8'h00))
		else $error("cursor on a slot whose flag bit is clear");

endmodule

>>> src/jksd_tokq.sv
// ----------------------------------------------------------------------------
// Token queue
// Two-entry queue between the classifier and the record assembler.
// ----------------------------------------------------------------------------
module jksd_tokq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jksd_pkg::token_t  tok_in,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output jksd_pkg::token_t  tok_out
);
	import jksd_pkg::*;

	token_t     mem_q [Q_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'(Q_DEPTH));
	assign empty   = (cnt_q == 2'd0);
	assign tok_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

>>> src/jksd_back.sv
// ----------------------------------------------------------------------------
// Record assembler
// Applies field tokens to the record, tracks joint and frame numbers, holds
// the configuration and queues finished records for the result side.
// ----------------------------------------------------------------------------
module jksd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tok_valid,
	input  jksd_pkg::token_t                    tok,
	output logic                                tok_pop,
	input  logic                                cfg_we,
	input  logic [jksd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jksd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                res_pop,
	output logic                                res_empty,
	output jksd_pkg::result_t                   res
);
	import jksd_pkg::*;

	logic [JLIM_W-1:0] joint_count_q;
	logic [FCNT_W-1:0] frame_count_q;
	logic [JCNT_W-1:0] jcnt_q;
	logic [FCNT_W-1:0] fcnt_q;
	field_t            fv_q [NUM_SLOTS];
	field_t            fv_next [NUM_SLOTS];

	result_t           out_mem_q [Q_DEPTH];
	logic              out_wr_q;
	logic              out_rd_q;
	logic [1:0]        out_cnt_q;
	logic              out_push;
	logic              out_pop;

	logic [JLIM_W-1:0] joint_lim;
	logic [FCNT_W-1:0] frame_lim;
	logic              last_joint;
	logic              last_frame;
	result_t           rec;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_count_q <= JLIM_W'(1);
			frame_count_q <= FCNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JOINT_COUNT: joint_count_q <= cfg_data[JLIM_W-1:0];
				REG_FRAME_COUNT: frame_count_q <= cfg_data[FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (joint_count_q == '0) begin
			joint_lim = JLIM_W'(1);
		end else if (joint_count_q > JLIM_W'(MAX_JOINTS)) begin
			joint_lim = JLIM_W'(MAX_JOINTS);
		end else begin
			joint_lim = joint_count_q;
		end
		frame_lim = (frame_count_q == '0) ? FCNT_W'(1) : frame_count_q;
	end

	assign last_joint = ({1'b0, jcnt_q} + JLIM_W'(1)) >= joint_lim;
	assign last_frame = ({1'b0, fcnt_q} + 17'd1) >= {1'b0, frame_lim};

	// merge the incoming field so a record can finish on its last value
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			fv_next[i] = (tok.wr && tok.slot == SLOT_W'(i)) ? tok.value : fv_q[i];
		end
	end

	always_comb begin
		rec.pos_x        = fv_next[SLOT_POS_X];
		rec.pos_y        = fv_next[SLOT_POS_Y];
		rec.pos_z        = fv_next[SLOT_POS_Z];
		rec.scale_x      = fv_next[SLOT_SCALE_X];
		rec.scale_y      = fv_next[SLOT_SCALE_Y];
		rec.scale_z      = fv_next[SLOT_SCALE_Z];
		rec.pitch        = fv_next[SLOT_PITCH];
		rec.yaw          = fv_next[SLOT_YAW];
		rec.roll         = fv_next[SLOT_ROLL];
		rec.joint_index  = jcnt_q;
		rec.frame_index  = fcnt_q;
		rec.sequence_end = last_joint && last_frame;
	end

	// a finishing token waits for room in the result queue
	assign tok_pop  = tok_valid && (!tok.done || out_cnt_q != 2'(Q_DEPTH));
	assign out_push = tok_pop && tok.done;
	assign out_pop  = res_pop && !res_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jcnt_q <= '0;
			fcnt_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				fv_q[i] <= slot_default(SLOT_W'(i));
			end
		end else if (tok_pop) begin
			if (tok.done) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					fv_q[i] <= slot_default(SLOT_W'(i));
				end
				if (last_joint) begin
					jcnt_q <= '0;
					fcnt_q <= last_frame ? '0 : fcnt_q + FCNT_W'(1);
				end else begin
					jcnt_q <= jcnt_q + JCNT_W'(1);
				end
			end else begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					fv_q[i] <= fv_next[i];
				end
			end
		end
	end

	// result queue
	assign res_empty = (out_cnt_q == 2'd0);
	assign res       = out_mem_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (out_push) begin
			out_mem_q[out_wr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) begin
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			out_cnt_q <= out_cnt_q + 2'(out_push) - 2'(out_pop);
		end
	end

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'(Q_DEPTH)) else $error("result queue overflow");

	a_done_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |=> !res_empty) else $error("finished record not queued");

	a_defaults_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |=> fv_q[SLOT_SCALE_Y] == SCALE_ONE && fv_q[SLOT_POS_X] == '0)
		else $error("record fields not returned to defaults");

endmodule

>>> src/joint_keyframe_stream_decoder.sv
// A record's last token passes through the token queue, then the result queue,
// before it shows on the result ports. Throughput: one byte per cycle while full
// is low; a record costs its flag byte plus two bytes per present field, and a
// record is emitted every cycle if they come that fast and records are popped.
// Reset (arst_n low, asynchronous): both queues empty, decoder waits for a
// flag byte, joint and frame numbers zero, both counts back to one.
// ----------------------------------------------------------------------------
// Joint keyframe stream decoder
// Decodes a flag-prefixed skeletal keyframe byte stream into joint records.
// ----------------------------------------------------------------------------
module joint_keyframe_stream_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          data_byte,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jksd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jksd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [15:0]                  pos_x,
	output logic signed [15:0]                  pos_y,
	output logic signed [15:0]                  pos_z,
	output logic signed [15:0]                  scale_x,
	output logic signed [15:0]                  scale_y,
	output logic signed [15:0]                  scale_z,
	output logic signed [15:0]                  pitch,
	output logic signed [15:0]                  yaw,
	output logic signed [15:0]                  roll,
	output logic [7:0]                          joint_index,
	output logic [15:0]                         frame_index,
	output logic                                sequence_end
);
	import jksd_pkg::*;

	logic    take;
	logic    tok_push;
	token_t  tok_in;
	token_t  tok_out;
	logic    tokq_full;
	logic    tokq_empty;
	logic    tok_pop;
	result_t res;

	assign full      = tokq_full;
	assign take      = push && !tokq_full;
	assign cfg_ready = 1'b1;

	jksd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.tok_push  (tok_push),
		.tok       (tok_in)
	);

	jksd_tokq u_tokq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (tok_push),
		.tok_in  (tok_in),
		.full    (tokq_full),
		.pop     (tok_pop),
		.empty   (tokq_empty),
		.tok_out (tok_out)
	);

	jksd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (!tokq_empty),
		.tok       (tok_out),
		.tok_pop   (tok_pop),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	assign pos_x        = res.pos_x;
	assign pos_y        = res.pos_y;
	assign pos_z        = res.pos_z;
	assign scale_x      = res.scale_x;
	assign scale_y      = res.scale_y;
	assign scale_z      = res.scale_z;
	assign pitch        = res.pitch;
	assign yaw          = res.yaw;
	assign roll         = res.roll;
	assign joint_index  = res.joint_index;
	assign frame_index  = res.frame_index;
	assign sequence_end = res.sequence_end;

endmodule

>>> bench/jksd_record_checker.sv
// ----------------------------------------------------------------------------
// Joint record checker
// Watches the byte, register and record channels of the keyframe decoder.
// It decodes every accepted byte on its own and compares each popped record
// field by field against the oldest record it has decoded.
// ----------------------------------------------------------------------------
module jksd_record_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [7:0]                      data_byte,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [jksd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jksd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [15:0]                     pos_x,
	input  logic [15:0]                     pos_y,
	input  logic [15:0]                     pos_z,
	input  logic [15:0]                     scale_x,
	input  logic [15:0]                     scale_y,
	input  logic [15:0]                     scale_z,
	input  logic [15:0]                     pitch,
	input  logic [15:0]                     yaw,
	input  logic [15:0]                     roll,
	input  logic [7:0]                      joint_index,
	input  logic [15:0]                     frame_index,
	input  logic                            sequence_end,
	output int                              mismatch_count,
	output int                              records_waiting
);

	import jksd_pkg::*;

	logic [7:0]        flags_r;
	logic [SLOT_W-1:0] cursor_r;   // 0 while a flag byte is due, else 1 + slot
	logic              lo_valid_r;
	logic [7:0]        lo_byte_r;
	field_t            vals_r [NUM_SLOTS];
	logic [JCNT_W-1:0] joint_r;
	logic [FCNT_W-1:0] frame_r;
	logic [JLIM_W-1:0] joint_limit_r;
	logic [FCNT_W-1:0] frame_limit_r;
	result_t           pending_records [$];
	result_t           want;
	int                err_n = 0;

	// slots 0..3 sit on flag bits 0..3; scale z shares bit 3, the rest shift down
	function automatic int first_present(input logic [7:0] flags, input int start);
		for (int s = start; s < NUM_SLOTS; s++)
			if (flags[(s > SLOT_SCALE_X) ? s - 1 : s])
				return s;
		return NUM_SLOTS;
	endfunction

	task automatic clear_record();
		for (int s = 0; s < NUM_SLOTS; s++)
			vals_r[s] = '0;
		vals_r[SLOT_SCALE_X] = SCALE_ONE;
		vals_r[SLOT_SCALE_Y] = SCALE_ONE;
		vals_r[SLOT_SCALE_Z] = SCALE_ONE;
		flags_r    = '0;
		cursor_r   = '0;
		lo_valid_r = 1'b0;
		lo_byte_r  = '0;
	endtask

	task automatic close_record();
		result_t rec;
		int      jl;
		int      fl;
		logic    last_joint;
		logic    last_frame;
		jl = (joint_limit_r == 0) ? 1 : int'(joint_limit_r);
		if (jl > MAX_JOINTS)
			jl = MAX_JOINTS;
		fl = (frame_limit_r == 0) ? 1 : int'(frame_limit_r);
		last_joint = (int'(joint_r) + 1) >= jl;
		last_frame = (int'(frame_r) + 1) >= fl;
		rec.pos_x        = vals_r[SLOT_POS_X];
		rec.pos_y        = vals_r[SLOT_POS_Y];
		rec.pos_z        = vals_r[SLOT_POS_Z];
		rec.scale_x      = vals_r[SLOT_SCALE_X];
		rec.scale_y      = vals_r[SLOT_SCALE_Y];
		rec.scale_z      = vals_r[SLOT_SCALE_Z];
		rec.pitch        = vals_r[SLOT_PITCH];
		rec.yaw          = vals_r[SLOT_YAW];
		rec.roll         = vals_r[SLOT_ROLL];
		rec.joint_index  = joint_r;
		rec.frame_index  = frame_r;
		rec.sequence_end = last_joint && last_frame;
		pending_records.push_back(rec);
		// a counter past a lowered limit wraps here as well
		if (last_joint) begin
			joint_r = '0;
			frame_r = last_frame ? '0 : frame_r + 1'b1;
		end else begin
			joint_r = joint_r + 1'b1;
		end
		clear_record();
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int s;
		if (cursor_r == 0) begin
			flags_r    = b;
			lo_valid_r = 1'b0;
			s = first_present(b, 0);
			if (s >= NUM_SLOTS)
				close_record();
			else
				cursor_r = SLOT_W'(s + 1);
		end else if (!lo_valid_r) begin
			lo_byte_r  = b;
			lo_valid_r = 1'b1;
		end else begin
			s = int'(cursor_r) - 1;
			vals_r[s]  = {b, lo_byte_r};
			lo_valid_r = 1'b0;
			lo_byte_r  = '0;
			s = first_present(flags_r, s + 1);
			if (s >= NUM_SLOTS)
				close_record();
			else
				cursor_r = SLOT_W'(s + 1);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			err_n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_record();
			joint_r       = '0;
			frame_r       = '0;
			joint_limit_r = JLIM_W'(1);
			frame_limit_r = FCNT_W'(1);
			pending_records.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_JOINT_COUNT)
					joint_limit_r = cfg_data[JLIM_W-1:0];
				else if (cfg_index == REG_FRAME_COUNT)
					frame_limit_r = cfg_data[FCNT_W-1:0];
			end
			if (push && !full)
				decode_byte(data_byte);
			if (pop && !empty) begin
				if (pending_records.size() == 0) begin
					$error("record transfer with no record decoded");
					err_n++;
				end else begin
					want = pending_records.pop_front();
					check_field("pos_x", want.pos_x, pos_x);
					check_field("pos_y", want.pos_y, pos_y);
					check_field("pos_z", want.pos_z, pos_z);
					check_field("scale_x", want.scale_x, scale_x);
					check_field("scale_y", want.scale_y, scale_y);
					check_field("scale_z", want.scale_z, scale_z);
					check_field("pitch", want.pitch, pitch);
					check_field("yaw", want.yaw, yaw);
					check_field("roll", want.roll, roll);
					check_field("joint_index", 16'(want.joint_index), 16'(joint_index));
					check_field("frame_index", want.frame_index, frame_index);
					check_field("sequence_end", 16'(want.sequence_end), 16'(sequence_end));
				end
			end
		end
		records_waiting <= pending_records.size();
		mismatch_count  <= err_n;
	end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Keyframe decoder testbench
// Feeds flag-prefixed joint records through the decoder under several joint
// and frame counts, with random bursts on the byte side and random stalls on
// the record side, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;

	import jksd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	// indexes outside the register list, the block must ignore them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

	typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_PERIODIC, RX_TRICKLE} rx_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [7:0]            data_byte = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic signed [15:0]    pos_x, pos_y, pos_z;
	logic signed [15:0]    scale_x, scale_y, scale_z;
	logic signed [15:0]    pitch, yaw, roll;
	logic [7:0]            joint_index;
	logic [15:0]           frame_index;
	logic                  sequence_end;
	int                    mismatch_count;
	int                    records_waiting;

	logic [7:0] byte_stream [$];
	int         hold_seq    = 0;
	int         hold_seen   = 0;
	int         hold_left   = 0;
	rx_mode_t   rx_mode     = RX_STREAM;
	int         rx_left     = 0;
	int         rx_tick     = 0;
	int         cycle_count = 0;

	joint_keyframe_stream_decoder dut (.*);

	jksd_record_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// record side: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 60);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_STREAM:   pop <= 1'b1;
				RX_COIN:     pop <= 1'($urandom_range(0, 1));
				RX_PERIODIC: pop <= (rx_tick % 3 == 0);
				default:     pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_flags();
		case ($urandom_range(0, 9))
			0:          return 8'h00;
			1, 2, 3:    return 8'h01 << $urandom_range(0, 7);
			default:    return 8'($urandom);
		endcase
	endfunction

	task automatic add_value(input logic [15:0] v);
		byte_stream.push_back(v[7:0]);
		byte_stream.push_back(v[15:8]);
	endtask

	task automatic add_record(input logic [7:0] flags);
		byte_stream.push_back(flags);
		for (int b = 0; b < 8; b++) begin
			if (flags[b]) begin
				add_value(pick_value());
				// the scale bit carries both x and z
				if (b == 3)
					add_value(pick_value());
			end
		end
	endtask

	task automatic build_random(input int min_bytes, input int min_records);
		int records;
		int k;
		records = 0;
		while (byte_stream.size() < min_bytes || records < min_records) begin
			if ($urandom_range(0, 9) == 0) begin
				// loose bytes that shift the record framing
				k = $urandom_range(1, 3);
				repeat (k) byte_stream.push_back(8'($urandom));
			end else begin
				add_record(pick_flags());
				records++;
			end
		end
		if ($urandom_range(0, 1)) begin
			// leave a record open across the next register writes
			byte_stream.push_back(8'($urandom_range(1, 255)));
			k = $urandom_range(0, 2);
			repeat (k) byte_stream.push_back(8'($urandom));
		end
	endtask

	task automatic send_stream(input bit steady);
		logic [7:0] b;
		int         burst_left;
		int         gap;
		burst_left = 0;
		while (byte_stream.size() > 0) begin
			b = byte_stream.pop_front();
			if (!steady && burst_left == 0) begin
				gap        = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
			push      <= 1'b1;
			data_byte <= b;
			@(posedge clk);
			while (full) @(posedge clk);
		end
		push <= 1'b0;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (records_waiting != 0) @(posedge clk);
		// a record may still be closing inside the block
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int i;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty record, a record with every field at edge values, scale pair only
		byte_stream.push_back(8'h00);
		byte_stream.push_back(8'hFF);
		add_value(16'h8000);
		add_value(16'h7FFF);
		add_value(16'hFFFF);
		add_value(16'h0000);
		add_value(16'h0100);
		add_value(16'h00FF);
		add_value(16'hFF00);
		add_value(16'h5AA5);
		add_value(16'hA55A);
		byte_stream.push_back(8'h08);
		add_value(16'h1234);
		add_value(16'hFEDC);
		send_stream(1'b1);
		drain();

		// zero counts behave as one
		cfg_write(REG_JOINT_COUNT, 16'd0);
		cfg_write(REG_FRAME_COUNT, 16'd0);
		cfg_valid <= 1'b0;
		build_random(24, 4);
		send_stream(1'b0);
		drain();

		cfg_write(REG_JOINT_COUNT, 16'd3);
		cfg_write(REG_FRAME_COUNT, 16'd2);
		cfg_valid <= 1'b0;
		build_random(24, 4);
		send_stream(1'b0);
		drain();

		// upper data bits are outside the joint count register
		cfg_write(REG_SPARE, 16'd7);
		cfg_write(REG_JOINT_COUNT, 16'hFE05);
		cfg_write(REG_FRAME_COUNT, 16'd3);
		cfg_valid <= 1'b0;
		build_random(24, 4);
		send_stream(1'b1);
		drain();

		// lower the joint count under a running counter
		cfg_write(REG_JOINT_COUNT, 16'd2);
		cfg_write(REG_FRAME_COUNT, 16'hFFFF);
		cfg_valid <= 1'b0;
		build_random(24, 4);
		send_stream(1'b0);
		drain();

		// full-width joint count, mostly empty records so the index climbs fast
		cfg_write(REG_JOINT_COUNT, 16'd256);
		cfg_write(REG_FRAME_COUNT, 16'd2);
		cfg_valid <= 1'b0;
		for (i = 0; i < 190; i++) begin
			if ($urandom_range(0, 15) == 0)
				add_record(pick_flags());
			else
				byte_stream.push_back(8'h00);
		end
		hold_seq <= hold_seq + 1;
		send_stream(1'b0);
		drain();

		// joint count above the maximum saturates; run past the wrap
		cfg_write(REG_JOINT_COUNT, 16'd511);
		cfg_valid <= 1'b0;
		for (i = 0; i < 70; i++)
			byte_stream.push_back(8'h00);
		send_stream(1'b0);
		drain();

		cfg_write(REG_TOP, 16'hFFFF);
		cfg_write(REG_JOINT_COUNT, 16'd1);
		cfg_write(REG_FRAME_COUNT, 16'd1);
		cfg_valid <= 1'b0;
		build_random(24, 4);
		send_stream(1'b0);
		drain();

		if (mismatch_count == 0 && records_waiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
src/jksd_pkg.sv
src/jksd_front.sv
src/jksd_tokq.sv
src/jksd_back.sv
src/joint_keyframe_stream_decoder.sv
bench/jksd_record_checker.sv
bench/tb_top.sv
